### design/psg_pkg.sv
// Shared codes for the PSG register dump stream parser.
package psg_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned REG_W   = 4;
	localparam int unsigned PHASE_W = 3;
	localparam int unsigned SIGPOS_W = 2;

	// parse phases
	localparam logic [PHASE_W-1:0] PH_SIGNATURE = 3'd0;
	localparam logic [PHASE_W-1:0] PH_COMMAND   = 3'd1;
	localparam logic [PHASE_W-1:0] PH_VALUE     = 3'd2;
	localparam logic [PHASE_W-1:0] PH_PAUSE     = 3'd3;
	localparam logic [PHASE_W-1:0] PH_ENDED     = 3'd4;
	localparam logic [PHASE_W-1:0] PH_BAD       = 3'd5;

	// event kinds
	localparam logic [KIND_W-1:0] EV_CONSUMED  = 3'd0;
	localparam logic [KIND_W-1:0] EV_WRITE     = 3'd1;
	localparam logic [KIND_W-1:0] EV_FRAME     = 3'd2;
	localparam logic [KIND_W-1:0] EV_MUSIC_END = 3'd3;
	localparam logic [KIND_W-1:0] EV_BAD_SIG   = 3'd4;
	localparam logic [KIND_W-1:0] EV_IGNORED   = 3'd5;

	// command bytes
	localparam logic [BYTE_W-1:0] CMD_MUSIC_END = 8'hFD;
	localparam logic [BYTE_W-1:0] CMD_PAUSE     = 8'hFE;
	localparam logic [BYTE_W-1:0] CMD_FRAME_END = 8'hFF;
	localparam logic [BYTE_W-1:0] REG_LAST      = 8'h0F;

	typedef logic [BYTE_W-1:0] byte_t;

	// expected signature byte: 'P', 'S', 'G', 0x1A
	function automatic byte_t sig_byte(input logic [SIGPOS_W-1:0] pos);
		byte_t b;
		case (pos)
			2'd0:    b = 8'h50;
			2'd1:    b = 8'h53;
			2'd2:    b = 8'h47;
			default: b = 8'h1A;
		endcase
		return b;
	endfunction

endpackage

### design/psg_register_stream_parser.sv
// An accepted byte waits in the input register until the result register can take it.
// One byte per cycle when not stalled; the phase update is a single decode step.
// in_stall follows out_stall only when both the input and result registers are full.
// Reset (arst_n low) returns the parser to the signature check and empties both registers.
// Top level of the PSG register dump stream parser.
module psg_register_stream_parser (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [psg_pkg::BYTE_W-1:0]   stream_byte,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [psg_pkg::KIND_W-1:0]   event_kind,
	output logic [psg_pkg::REG_W-1:0]    reg_index,
	output logic [psg_pkg::BYTE_W-1:0]   reg_value,
	output logic [psg_pkg::BYTE_W-1:0]   idle_frames,
	output logic                         unknown_command
);
	import psg_pkg::*;

	logic                valid_s1;
	logic [BYTE_W-1:0]   byte_s1;
	logic                valid_s2;
	logic [KIND_W-1:0]   kind_s2;
	logic [REG_W-1:0]    index_s2;
	logic [BYTE_W-1:0]   value_s2;
	logic [BYTE_W-1:0]   idle_s2;
	logic                unk_s2;

	logic [PHASE_W-1:0]  phase_q;
	logic [SIGPOS_W-1:0] sigpos_q;
	logic [REG_W-1:0]    pending_q;

	logic                adv_s2;
	logic                adv_s1;
	logic [PHASE_W-1:0]  phase_d;
	logic [SIGPOS_W-1:0] sigpos_d;
	logic [REG_W-1:0]    pending_d;
	logic [KIND_W-1:0]   kind_d;
	logic [REG_W-1:0]    index_d;
	logic [BYTE_W-1:0]   value_d;
	logic [BYTE_W-1:0]   idle_d;
	logic                unk_d;

	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = valid_s1 && adv_s2;
	assign in_stall = valid_s1 && !adv_s2;

	always_comb begin
		phase_d   = phase_q;
		sigpos_d  = sigpos_q;
		pending_d = pending_q;
		kind_d    = EV_IGNORED;
		index_d   = '0;
		value_d   = '0;
		idle_d    = '0;
		unk_d     = 1'b0;
		case (phase_q)
			PH_SIGNATURE: begin
				if (byte_s1 == sig_byte(sigpos_q)) begin
					kind_d = EV_CONSUMED;
					if (sigpos_q == '1) begin
						phase_d  = PH_COMMAND;
						sigpos_d = '0;
					end else begin
						sigpos_d = sigpos_q + 1'b1;
					end
				end else begin
					kind_d  = EV_BAD_SIG;
					phase_d = PH_BAD;
				end
			end
			PH_COMMAND: begin
				if (byte_s1 inside {[8'h00:REG_LAST]}) begin
					pending_d = byte_s1[REG_W-1:0];
					phase_d   = PH_VALUE;
					kind_d    = EV_CONSUMED;
				end else if (byte_s1 == CMD_FRAME_END) begin
					kind_d = EV_FRAME;
				end else if (byte_s1 == CMD_PAUSE) begin
					phase_d = PH_PAUSE;
					kind_d  = EV_CONSUMED;
				end else if (byte_s1 == CMD_MUSIC_END) begin
					phase_d = PH_ENDED;
					kind_d  = EV_MUSIC_END;
				end else begin
					kind_d = EV_FRAME;
					unk_d  = 1'b1;
				end
			end
			PH_VALUE: begin
				kind_d  = EV_WRITE;
				index_d = pending_q;
				value_d = byte_s1;
				phase_d = PH_COMMAND;
			end
			PH_PAUSE: begin
				kind_d  = EV_FRAME;
				idle_d  = byte_s1;
				phase_d = PH_COMMAND;
			end
			default: begin
				kind_d = EV_IGNORED;
			end
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			valid_s2  <= 1'b0;
			phase_q   <= PH_SIGNATURE;
			sigpos_q  <= '0;
			pending_q <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
			end
			if (adv_s1) begin
				phase_q   <= phase_d;
				sigpos_q  <= sigpos_d;
				pending_q <= pending_d;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			byte_s1 <= stream_byte;
		end
		if (adv_s1) begin
			kind_s2  <= kind_d;
			index_s2 <= index_d;
			value_s2 <= value_d;
			idle_s2  <= idle_d;
			unk_s2   <= unk_d;
		end
	end

	assign out_valid       = valid_s2;
	assign event_kind      = kind_s2;
	assign reg_index       = index_s2;
	assign reg_value       = value_s2;
	assign idle_frames     = idle_s2;
	assign unknown_command = unk_s2;

endmodule

### design/psg_checker.sv
// Port-level checks for the PSG register dump stream parser, bound to the top level.
module psg_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_stall,
	input logic [psg_pkg::BYTE_W-1:0] stream_byte,
	input logic                       out_valid,
	input logic                       out_stall,
	input logic [psg_pkg::KIND_W-1:0] event_kind,
	input logic [psg_pkg::REG_W-1:0]  reg_index,
	input logic [psg_pkg::BYTE_W-1:0] reg_value,
	input logic [psg_pkg::BYTE_W-1:0] idle_frames,
	input logic                       unknown_command
);
	import psg_pkg::*;

	// a stalled input request keeps its valid and byte
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(stream_byte))
		else $error("input changed while stalled");

	// a stalled result request keeps its valid and kind
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(event_kind))
		else $error("result changed while stalled");

	// register fields are only populated on a write
	a_write_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && event_kind != EV_WRITE |-> reg_index == '0 && reg_value == '0)
		else $error("register fields set outside a write");

	// unknown command flag only on a frame end
	a_unknown: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unknown_command |-> event_kind == EV_FRAME && idle_frames == '0)
		else $error("unknown command flag on wrong event");

	// idle count only on a frame end from a pause
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle_frames != '0 |-> event_kind == EV_FRAME && !unknown_command)
		else $error("idle frames on wrong event");

endmodule

bind psg_register_stream_parser psg_checker u_psg_checker (.*);
